/* rtl/idea_pkg.sv */
// ----------------------------------------------------------------------------
// IDEA cipher package
// Shared types, register indexes and the modulo 65537 multiply helpers.
// ----------------------------------------------------------------------------
package idea_pkg;

   localparam int unsigned SUB_W     = 16;
   localparam int unsigned BLOCK_W   = 64;
   localparam int unsigned KEY_IDX_W = 6;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 2'd2;

   typedef struct packed {
      logic                 valid;
      logic [KEY_IDX_W-1:0] index;
      logic [SUB_W-1:0]     data;
   } key_wr_type;

   // first half of a multiply: raw product plus the zero-operand result
   typedef struct packed {
      logic [2*SUB_W-1:0] prod;
      logic               zero;
      logic [SUB_W-1:0]   fix;
   } mul_stage_type;

   function automatic mul_stage_type mul_start(input logic [SUB_W-1:0] a,
                                               input logic [SUB_W-1:0] b);
      mul_stage_type m;
      m.prod = 32'(a) * 32'(b);
      m.zero = (a == 16'd0) || (b == 16'd0);
      m.fix  = 16'd1 - ((a == 16'd0) ? b : a);
      return m;
   endfunction

   // second half: low minus high, plus one on borrow
   function automatic logic [SUB_W-1:0] mul_end(input mul_stage_type m);
      logic [SUB_W-1:0] lo;
      logic [SUB_W-1:0] hi;
      lo = m.prod[SUB_W-1:0];
      hi = m.prod[2*SUB_W-1:SUB_W];
      if (m.zero) begin
         return m.fix;
      end else if (lo >= hi) begin
         return lo - hi;
      end else begin
         return lo - hi + 16'd1;
      end
   endfunction

endpackage

/* rtl/idea_inv.sv */
// ----------------------------------------------------------------------------
// IDEA multiplicative inverse
// Raises a subkey to the power 65535 modulo 65537 by square and multiply,
// sixteen iterations, each a multiply start and a multiply end.
// ----------------------------------------------------------------------------
module idea_inv import idea_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUB_W-1:0] value,
   output logic             done,
   output logic [SUB_W-1:0] result
);

   logic             run_ff;
   logic             phase_ff;
   logic [3:0]       cnt_ff;
   logic             done_ff;
   logic [SUB_W-1:0] r_ff;
   logic [SUB_W-1:0] b_ff;
   mul_stage_type    mr_ff;
   mul_stage_type    mb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (start) begin
         run_ff   <= 1'b1;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (run_ff) begin
            phase_ff <= ~phase_ff;
            if (phase_ff) begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  run_ff  <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff <= 16'd1;
         b_ff <= value;
      end else if (run_ff && phase_ff) begin
         r_ff <= mul_end(mr_ff);
         b_ff <= mul_end(mb_ff);
      end
      if (run_ff && !phase_ff) begin
         mr_ff <= mul_start(r_ff, b_ff);
         mb_ff <= mul_start(b_ff, b_ff);
      end
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

/* rtl/idea_keysched.sv */
// ----------------------------------------------------------------------------
// IDEA key schedule
// Holds the key registers and writes the subkeys into the cells one at a
// time, inverting them for decryption.
// ----------------------------------------------------------------------------
module idea_keysched import idea_pkg::*; #(
   parameter int ROUNDS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BLOCK_W-1:0]   csr_data,
   output logic                 busy,
   output key_wr_type           key_wr
);

   typedef enum logic [2:0] {
      KS_IDLE = 3'b001,
      KS_STEP = 3'b010,
      KS_INV  = 3'b100
   } ks_state_type;

   localparam logic [3:0] LAST_RND = 4'(ROUNDS);

   ks_state_type         st_ff;
   logic [3:0]           rnd_ff;
   logic [2:0]           wrd_ff;
   logic [BLOCK_W-1:0]   key_high_ff;
   logic [BLOCK_W-1:0]   key_low_ff;
   logic                 decrypt_ff;

   logic                 cfg_hit;
   logic [3:0]           rr;
   logic [KEY_IDX_W-1:0] base;
   logic [KEY_IDX_W-1:0] dst;
   logic [KEY_IDX_W-1:0] src;
   logic                 outer_rnd;
   logic [6:0]           grp;
   logic [6:0]           off;
   logic [7:0]           pos;
   logic [255:0]         dbl;
   logic [SUB_W-1:0]     ek;
   logic                 need_inv;
   logic                 need_neg;
   logic                 last;
   logic                 inv_start;
   logic                 inv_done;
   logic [SUB_W-1:0]     inv_res;
   logic                 step_done;

   assign cfg_hit = csr_write && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW ||
                                  csr_index == CSR_MODE);

   always_comb begin
      rr        = LAST_RND - rnd_ff;
      base      = 6'(rr) * 6'd6;
      dst       = 6'(rnd_ff) * 6'd6 + 6'(wrd_ff);
      outer_rnd = (rnd_ff == 4'd0) || (rnd_ff == LAST_RND);
      if (!decrypt_ff) begin
         src = dst;
      end else begin
         unique case (wrd_ff)
            3'd0:    src = base;
            3'd1:    src = base + (outer_rnd ? 6'd1 : 6'd2);
            3'd2:    src = base + (outer_rnd ? 6'd2 : 6'd1);
            3'd3:    src = base + 6'd3;
            3'd4:    src = base - 6'd2;
            3'd5:    src = base - 6'd1;
            default: src = base;
         endcase
      end
      // subkey src is the key rotated by 25 per group of eight, word src mod 8
      grp      = 7'(src[5:3]);
      off      = {src[2:0], 4'b0000} + grp * 7'd25;
      pos      = 8'd255 - {1'b0, off};
      dbl      = {key_high_ff, key_low_ff, key_high_ff, key_low_ff};
      ek       = dbl[pos -: 16];
      need_inv = decrypt_ff && (wrd_ff == 3'd0 || wrd_ff == 3'd3);
      need_neg = decrypt_ff && (wrd_ff == 3'd1 || wrd_ff == 3'd2);
      last     = (rnd_ff == LAST_RND) && (wrd_ff == 3'd3);
   end

   assign inv_start = (st_ff == KS_STEP) && need_inv;
   assign step_done = ((st_ff == KS_STEP) && !need_inv) || ((st_ff == KS_INV) && inv_done);

   idea_inv u_inv (
      .clock  (clock),
      .reset  (reset),
      .start  (inv_start),
      .value  (ek),
      .done   (inv_done),
      .result (inv_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= KS_STEP;
         rnd_ff      <= '0;
         wrd_ff      <= '0;
         key_high_ff <= '0;
         key_low_ff  <= '0;
         decrypt_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            priority if (csr_index == CSR_KEY_HIGH) begin
               key_high_ff <= csr_data;
            end else if (csr_index == CSR_KEY_LOW) begin
               key_low_ff <= csr_data;
            end else if (csr_index == CSR_MODE) begin
               decrypt_ff <= csr_data[0];
            end
         end
         priority if (cfg_hit) begin
            st_ff  <= KS_STEP;
            rnd_ff <= '0;
            wrd_ff <= '0;
         end else if (step_done) begin
            if (last) begin
               st_ff <= KS_IDLE;
            end else begin
               st_ff <= KS_STEP;
               if (wrd_ff == 3'd5) begin
                  wrd_ff <= '0;
                  rnd_ff <= rnd_ff + 4'd1;
               end else begin
                  wrd_ff <= wrd_ff + 3'd1;
               end
            end
         end else if (inv_start) begin
            st_ff <= KS_INV;
         end
      end
   end

   always_comb begin
      key_wr.valid = step_done;
      key_wr.index = dst;
      if (need_inv) begin
         key_wr.data = inv_res;
      end else if (need_neg) begin
         key_wr.data = 16'd0 - ek;
      end else begin
         key_wr.data = ek;
      end
   end

   assign busy = (st_ff != KS_IDLE);

endmodule

/* rtl/idea_round.sv */
// ----------------------------------------------------------------------------
// IDEA round cell
// One full round in six stages, holding its own six subkeys.
// ----------------------------------------------------------------------------
module idea_round import idea_pkg::*; #(
   parameter int KEY_BASE = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  key_wr_type         key_wr,
   input  logic               in_valid,
   input  logic [BLOCK_W-1:0] in_data,
   output logic               out_valid,
   output logic [BLOCK_W-1:0] out_data
);

   logic [SUB_W-1:0] k_ff [6];
   logic [5:0]       v_ff;
   mul_stage_type    pa_ff, pd_ff, pt0_ff, pt1_ff;
   logic [SUB_W-1:0] a_ff [2:5];
   logic [SUB_W-1:0] b_ff [1:5];
   logic [SUB_W-1:0] c_ff [1:5];
   logic [SUB_W-1:0] d_ff [2:5];
   logic [SUB_W-1:0] t0_ff;
   logic [SUB_W-1:0] t0_hold_ff;
   logic [BLOCK_W-1:0] out_ff;
   logic [SUB_W-1:0] t1, t2;

   for (genvar j = 0; j < 6; j++) begin : g_key
      always_ff @(posedge clock) begin
         if (key_wr.valid && key_wr.index == 6'(KEY_BASE + j)) begin
            k_ff[j] <= key_wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   assign t1 = mul_end(pt1_ff);
   assign t2 = t0_hold_ff + t1;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff    <= mul_start(in_data[63:48], k_ff[0]);
         pd_ff    <= mul_start(in_data[15:0], k_ff[3]);
         b_ff[1]  <= in_data[47:32] + k_ff[1];
         c_ff[1]  <= in_data[31:16] + k_ff[2];

         a_ff[2]  <= mul_end(pa_ff);
         d_ff[2]  <= mul_end(pd_ff);
         b_ff[2]  <= b_ff[1];
         c_ff[2]  <= c_ff[1];

         pt0_ff   <= mul_start(k_ff[4], a_ff[2] ^ c_ff[2]);
         a_ff[3]  <= a_ff[2];
         b_ff[3]  <= b_ff[2];
         c_ff[3]  <= c_ff[2];
         d_ff[3]  <= d_ff[2];

         t0_ff    <= mul_end(pt0_ff);
         a_ff[4]  <= a_ff[3];
         b_ff[4]  <= b_ff[3];
         c_ff[4]  <= c_ff[3];
         d_ff[4]  <= d_ff[3];

         pt1_ff   <= mul_start(k_ff[5], t0_ff + (b_ff[4] ^ d_ff[4]));
         a_ff[5]  <= a_ff[4];
         b_ff[5]  <= b_ff[4];
         c_ff[5]  <= c_ff[4];
         d_ff[5]  <= d_ff[4];

         out_ff   <= {a_ff[5] ^ t1, c_ff[5] ^ t1, b_ff[5] ^ t2, d_ff[5] ^ t2};
      end
   end

   // t0 travels one stage behind its product
   always_ff @(posedge clock) begin
      if (adv) begin
         t0_hold_ff <= t0_ff;
      end
   end

   assign out_valid = v_ff[5];
   assign out_data  = out_ff;

endmodule

/* rtl/idea_final.sv */
// ----------------------------------------------------------------------------
// IDEA output cell
// Output half-round in two stages, holding the last four subkeys.
// ----------------------------------------------------------------------------
module idea_final import idea_pkg::*; #(
   parameter int KEY_BASE = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  key_wr_type         key_wr,
   input  logic               in_valid,
   input  logic [BLOCK_W-1:0] in_data,
   output logic               out_valid,
   output logic [BLOCK_W-1:0] out_data
);

   logic [SUB_W-1:0]   k_ff [4];
   logic [1:0]         v_ff;
   mul_stage_type      p0_ff, p3_ff;
   logic [SUB_W-1:0]   y1_ff, y2_ff;
   logic [BLOCK_W-1:0] out_ff;

   for (genvar j = 0; j < 4; j++) begin : g_key
      always_ff @(posedge clock) begin
         if (key_wr.valid && key_wr.index == 6'(KEY_BASE + j)) begin
            k_ff[j] <= key_wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff  <= mul_start(in_data[63:48], k_ff[0]);
         y1_ff  <= in_data[31:16] + k_ff[1];
         y2_ff  <= in_data[47:32] + k_ff[2];
         p3_ff  <= mul_start(in_data[15:0], k_ff[3]);
         out_ff <= {mul_end(p0_ff), y1_ff, y2_ff, mul_end(p3_ff)};
      end
   end

   assign out_valid = v_ff[1];
   assign out_data  = out_ff;

endmodule

/* rtl/idea_block_cipher_unit.sv */
// ----------------------------------------------------------------------------
// IDEA block cipher unit
// Enciphers or deciphers 64-bit words under a 128-bit key.
// ----------------------------------------------------------------------------
// One word is taken per clock unless req_stall holds it off. Each round is a
// cell of six stages (two per chained multiply), the output half-round two
// more, and rsp_out_block is registered behind them. A two-word output skid
// lets the cell chain move while a result waits. After reset and after each key or
// mode write the schedule rewrites the subkeys, one per clock in encrypt mode and
// pausing for each of the 2*ROUNDS+2 multiplicative inverses in decrypt mode, and
// req_stall stays high meanwhile.
module idea_block_cipher_unit import idea_pkg::*; #(
   parameter int ROUNDS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BLOCK_W-1:0]   req_in_block,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BLOCK_W-1:0]   rsp_out_block,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BLOCK_W-1:0]   csr_data
);

   logic               busy;
   key_wr_type         key_wr;
   logic               adv;
   logic [ROUNDS:0]    cv;
   logic [BLOCK_W-1:0] cd [ROUNDS+1];
   logic               fv;
   logic [BLOCK_W-1:0] fd;
   logic               rsp_valid_ff;
   logic [BLOCK_W-1:0] rsp_block_ff;
   logic               skid_valid_ff;
   logic [BLOCK_W-1:0] skid_block_ff;
   logic               out_free;

   idea_keysched #(.ROUNDS(ROUNDS)) u_keysched (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (busy),
      .key_wr    (key_wr)
   );

   assign adv       = !skid_valid_ff;
   assign req_stall = busy || !adv;
   assign cv[0]     = req_valid && !req_stall;
   assign cd[0]     = req_in_block;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      idea_round #(.KEY_BASE(6 * r)) u_round (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .key_wr    (key_wr),
         .in_valid  (cv[r]),
         .in_data   (cd[r]),
         .out_valid (cv[r+1]),
         .out_data  (cd[r+1])
      );
   end

   idea_final #(.KEY_BASE(6 * ROUNDS)) u_final (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .key_wr    (key_wr),
      .in_valid  (cv[ROUNDS]),
      .in_data   (cd[ROUNDS]),
      .out_valid (fv),
      .out_data  (fd)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= adv && fv;
         end
      end else if (adv && fv) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_block_ff <= skid_valid_ff ? skid_block_ff : fd;
      end else if (adv && fv) begin
         skid_block_ff <= fd;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_block = rsp_block_ff;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a word while the output register is empty");

   a_cfg_starts_rebuild: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW ||
                     csr_index == CSR_MODE)) |=> busy)
      else $error("key or mode write did not start a subkey rebuild");

   a_key_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      key_wr.valid |-> req_stall)
      else $error("subkey written while words may enter");
`endif

endmodule

/* bench/idea_block_cipher_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IDEA block cipher unit testbench
// Drives 64-bit words through the cipher under several keys and both modes.
// Each accepted word is put through the cipher here as well, and every output word is
// compared in order with that value. The sender and the receiver idle at
// random; the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module idea_block_cipher_unit_tb;
   import idea_pkg::*;

   localparam int NUM_ROUNDS  = 8;
   localparam int NUM_SUBKEYS = 6 * NUM_ROUNDS + 4;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 6 * NUM_ROUNDS + 12;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [BLOCK_W-1:0]   req_in_block;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [BLOCK_W-1:0]   rsp_out_block;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BLOCK_W-1:0]   csr_data;

   logic [63:0]  cipher_key_high;
   logic [63:0]  cipher_key_low;
   logic         cipher_decrypt;
   logic [15:0]  subkeys [NUM_SUBKEYS];
   logic [63:0]  expected_blocks [$];

   int error_count;
   int cycle_count;
   int send_gap_pct;
   int recv_stall_pct;
   int recv_hold_cycles;

   idea_block_cipher_unit #(.ROUNDS(NUM_ROUNDS)) dut (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
      longint unsigned x;
      longint unsigned y;
      longint unsigned p;
      x = (a == 0) ? 65536 : a;
      y = (b == 0) ? 65536 : b;
      p = (x * y) % 65537;
      return p[15:0];
   endfunction

   function automatic logic [15:0] mul_inv(input logic [15:0] a);
      logic [15:0] r;
      logic [15:0] base;
      int          e;
      r    = 16'd1;
      base = a;
      e    = 65535;
      while (e != 0) begin
         if (e[0]) r = mul_mod(r, base);
         base = mul_mod(base, base);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic void rebuild_subkeys();
      logic [15:0]  ek [56];
      logic [127:0] k;
      int           src;
      k = {cipher_key_high, cipher_key_low};
      for (int n = 0; n < 56; n += 8) begin
         for (int i = 0; i < 8; i++) ek[n + i] = k[127 - 16 * i -: 16];
         k = {k[102:0], k[127:103]};
      end
      for (int i = 0; i < NUM_SUBKEYS; i++) subkeys[i] = 16'd0;
      if (!cipher_decrypt) begin
         for (int i = 0; i < NUM_SUBKEYS; i++) subkeys[i] = ek[i];
         return;
      end
      for (int r = 0; r <= NUM_ROUNDS; r++) begin
         src = 6 * (NUM_ROUNDS - r);
         subkeys[6 * r] = mul_inv(ek[src]);
         if (r == 0 || r == NUM_ROUNDS) begin
            subkeys[6 * r + 1] = -ek[src + 1];
            subkeys[6 * r + 2] = -ek[src + 2];
         end else begin
            subkeys[6 * r + 1] = -ek[src + 2];
            subkeys[6 * r + 2] = -ek[src + 1];
         end
         subkeys[6 * r + 3] = mul_inv(ek[src + 3]);
         if (r < NUM_ROUNDS) begin
            subkeys[6 * r + 4] = ek[src - 2];
            subkeys[6 * r + 5] = ek[src - 1];
         end
      end
   endfunction

   function automatic logic [63:0] cipher_block(input logic [63:0] blk);
      logic [15:0] x0, x1, x2, x3, a, b, c, d, t0, t1, t2;
      int          k;
      {x0, x1, x2, x3} = blk;
      k = 0;
      for (int r = 0; r < NUM_ROUNDS; r++) begin
         a  = mul_mod(x0, subkeys[k]);
         b  = x1 + subkeys[k + 1];
         c  = x2 + subkeys[k + 2];
         d  = mul_mod(x3, subkeys[k + 3]);
         t0 = mul_mod(subkeys[k + 4], a ^ c);
         t1 = mul_mod(subkeys[k + 5], t0 + (b ^ d));
         t2 = t0 + t1;
         x0 = a ^ t1;
         x3 = d ^ t2;
         x1 = c ^ t1;
         x2 = b ^ t2;
         k += 6;
      end
      return {mul_mod(x0, subkeys[k]), 16'(x2 + subkeys[k + 1]),
              16'(x1 + subkeys[k + 2]), mul_mod(x3, subkeys[k + 3])};
   endfunction

   function automatic logic [63:0] random_block();
      logic [63:0] blk;
      for (int i = 0; i < 4; i++) begin
         blk[16 * i +: 16] = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
      end
      return blk;
   endfunction

   // sender: ends on a falling edge with the word accepted
   task automatic send_word(input logic [63:0] blk);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_in_block <= blk;
      do @(posedge clock); while (req_stall);
      expected_blocks.push_back(cipher_block(blk));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_KEY_HIGH: cipher_key_high = value;
         CSR_KEY_LOW:  cipher_key_low  = value;
         CSR_MODE:     cipher_decrypt  = value[0];
         default:      return;
      endcase
      rebuild_subkeys();
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (recv_hold_cycles > 0) begin
         recv_hold_cycles <= recv_hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $error("out_block: unexpected word %h", rsp_out_block);
            error_count++;
         end else begin
            if (rsp_out_block !== expected_blocks[0]) begin
               $error("out_block: expected %h, got %h", expected_blocks[0], rsp_out_block);
               error_count++;
            end
            void'(expected_blocks.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_reset_key();
      send_word(64'h0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h0000_FFFF_0000_FFFF);
      send_word(64'h0001_0000_8000_0001);
      send_word(64'hAAAA_5555_AAAA_5555);
   endtask

   task automatic test_known_key();
      write_reg(CSR_KEY_HIGH, 64'h0001_0002_0003_0004);
      write_reg(CSR_KEY_LOW, 64'h0005_0006_0007_0008);
      send_word(64'h0000_0001_0002_0003);
      send_word(64'h0000_0000_0000_0000);
      send_word(64'h5555_AAAA_5555_AAAA);
   endtask

   task automatic test_decrypt();
      write_reg(CSR_MODE, 64'd1);
      send_word(64'h11FB_ED2B_0198_6DE5);
      send_word(64'h0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_KEY_HIGH, 64'h0);
      send_word(64'h0000_1234_0000_5678);
   endtask

   task automatic test_unused_index();
      write_reg(2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h0123_4567_89AB_CDEF);
   endtask

   task automatic test_wide_mode();
      write_reg(CSR_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
      write_reg(CSR_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h0);
      send_word(64'hFFFF_0000_FFFF_0000);
      write_reg(CSR_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(64'h0);
      send_word(64'hFFFF_0000_FFFF_0000);
   endtask

   task automatic test_random_phase(input int gap_pct, input int stall_pct, input int count);
      write_reg(CSR_KEY_HIGH, {$urandom, $urandom});
      write_reg(CSR_KEY_LOW, {$urandom, $urandom});
      write_reg(CSR_MODE, 64'($urandom_range(1)));
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) send_word(random_block());
   endtask

   task automatic test_backpressure();
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      wait_idle();
      recv_hold_cycles = 400;
      for (int i = 0; i < 120; i++) send_word(random_block());
      wait_idle();
      for (int i = 0; i < 40; i++) send_word(random_block());
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_block     = '0;
      rsp_stall        = 1'b0;
      csr_write        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      error_count      = 0;
      cycle_count      = 0;
      send_gap_pct     = 0;
      recv_stall_pct   = 0;
      recv_hold_cycles = 0;
      cipher_key_high  = '0;
      cipher_key_low   = '0;
      cipher_decrypt   = 1'b0;
      rebuild_subkeys();
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_reset_key();
      test_known_key();
      test_decrypt();
      test_unused_index();
      test_wide_mode();
      test_random_phase(8, 84, 300);
      test_random_phase(84, 8, 300);
      test_random_phase(0, 0, 300);
      test_backpressure();
      wait_idle();

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/idea_pkg.sv
rtl/idea_inv.sv
rtl/idea_keysched.sv
rtl/idea_round.sv
rtl/idea_final.sv
rtl/idea_block_cipher_unit.sv
bench/idea_block_cipher_unit_tb.sv
